@@ hdl/eswf_pkg.sv @@
// Package for the escaped-text to float-word decoder.
// Holds character codes, the queue item type and the escape map function.
// No dependencies.
package eswf_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_SEVEN     = 8'h37;
  localparam logic [7:0] CHAR_EIGHT     = 8'h38;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_V         = 8'h76;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_A         = 8'h61;
  localparam logic [7:0] CHAR_B         = 8'h62;

  localparam logic [1:0] LAST_SLOT = 2'd3;

  // One decoded step handed from front to back.
  typedef struct packed {
    logic       have;  // a byte was decoded
    logic [7:0] data;
    logic       err;   // octal escape of this byte began with 8 or 9
    logic       last;  // end of content: drop partial word after this
  } byte_item_t;

  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CHAR_T:  r = 8'd9;
      CHAR_N:  r = 8'd10;
      CHAR_V:  r = 8'd11;
      CHAR_F:  r = 8'd12;
      CHAR_R:  r = 8'd13;
      CHAR_A:  r = 8'd7;
      CHAR_B:  r = 8'd8;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/eswf_front.sv @@
// Front end: accepts characters and decodes C escapes into bytes.
// Depends on eswf_pkg.
module eswf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  input  logic                q_full,
  output logic                in_ready,
  output logic                push,
  output eswf_pkg::byte_item_t push_item
);
  import eswf_pkg::*;

  typedef enum logic [1:0] {
    PH_NORMAL,
    PH_AFTER_BS,
    PH_OCT2,
    PH_OCT3
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] octal_value, octal_value_next;
  logic       octal_stopped, octal_stopped_next;
  logic       err_pending, err_pending_next;

  logic       accept;
  logic       is_digit, is_octal;
  logic [7:0] taken_value;
  logic       taken_stopped;
  byte_item_t item;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
  assign is_octal = (in_char >= CHAR_ZERO) && (in_char <= CHAR_SEVEN);

  // One octal position: shift in a digit, or stop on anything else.
  always_comb begin
    if (!octal_stopped && is_octal) begin
      taken_value   = {octal_value[4:0], in_char[2:0]};
      taken_stopped = octal_stopped;
    end else begin
      taken_value   = octal_value;
      taken_stopped = 1'b1;
    end
  end

  always_comb begin
    phase_next         = phase;
    octal_value_next   = octal_value;
    octal_stopped_next = octal_stopped;
    err_pending_next   = err_pending;
    item.have          = 1'b0;
    item.data          = in_char;
    item.err           = 1'b0;
    item.last          = in_last;
    case (phase)
      PH_AFTER_BS: begin
        if (is_digit) begin
          if (in_char >= CHAR_EIGHT) begin
            err_pending_next   = 1'b1;
            octal_value_next   = 8'd0;
            octal_stopped_next = 1'b1;
          end else begin
            octal_value_next   = {5'd0, in_char[2:0]};
            octal_stopped_next = 1'b0;
          end
          phase_next = PH_OCT2;
        end else begin
          item.have  = 1'b1;
          item.data  = map_escape(in_char);
          phase_next = PH_NORMAL;
        end
      end
      PH_OCT2: begin
        octal_value_next   = taken_value;
        octal_stopped_next = taken_stopped;
        phase_next         = PH_OCT3;
      end
      PH_OCT3: begin
        item.have          = 1'b1;
        item.data          = taken_value;
        item.err           = err_pending;
        octal_value_next   = 8'd0;
        octal_stopped_next = 1'b0;
        err_pending_next   = 1'b0;
        phase_next         = PH_NORMAL;
      end
      default: begin
        if (in_char == CHAR_BACKSLASH) begin
          phase_next = PH_AFTER_BS;
        end else begin
          item.have  = 1'b1;
          phase_next = PH_NORMAL;
        end
      end
    endcase
    // drop any pending escape at end of content
    if (in_last) begin
      phase_next         = PH_NORMAL;
      octal_value_next   = 8'd0;
      octal_stopped_next = 1'b0;
      err_pending_next   = 1'b0;
    end
  end

  assign push      = accept && (item.have || item.last);
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_NORMAL;
      octal_value   <= 8'd0;
      octal_stopped <= 1'b0;
      err_pending   <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      octal_value   <= octal_value_next;
      octal_stopped <= octal_stopped_next;
      err_pending   <= err_pending_next;
    end
  end

endmodule

@@ hdl/eswf_queue.sv @@
// Short queue of decoded bytes between front and back ends.
// Depends on eswf_pkg.
module eswf_queue #(
  parameter int Depth = eswf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  eswf_pkg::byte_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output eswf_pkg::byte_item_t head_item
);
  import eswf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  byte_item_t          slots [Depth];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/eswf_back.sv @@
// Back end: packs decoded bytes little-endian into 32-bit words, output register.
// Depends on eswf_pkg.
module eswf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  eswf_pkg::byte_item_t head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_word,
  output logic                 out_err
);
  import eswf_pkg::*;

  logic [1:0]  bytes_held;
  logic [23:0] word_shift;
  logic        error_seen;
  logic        emit;

  assign pop  = q_valid && (!out_valid || out_ready);
  assign emit = pop && head_item.have && (bytes_held == LAST_SLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held <= 2'd0;
      word_shift <= 24'd0;
      error_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        // drop the partial word at end of content
        if (head_item.last) begin
          bytes_held <= 2'd0;
          word_shift <= 24'd0;
          error_seen <= 1'b0;
        end else if (head_item.have) begin
          if (bytes_held == LAST_SLOT) begin
            bytes_held <= 2'd0;
            word_shift <= 24'd0;
            error_seen <= 1'b0;
          end else begin
            word_shift[8*bytes_held +: 8] <= head_item.data;
            bytes_held <= bytes_held + 2'd1;
            error_seen <= error_seen | head_item.err;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= {head_item.data, word_shift};
      out_err  <= error_seen | head_item.err;
    end
  end

endmodule

@@ hdl/escaped_text_to_float_words.sv @@
// Top level of the escaped-text to float-word decoder.
// Instantiates eswf_front, eswf_queue and eswf_back; depends on eswf_pkg.
//
//  channel  | direction | tdata                    | tuser       | tlast
//  ---------+-----------+--------------------------+-------------+---------------
//  s_*      | in        | [7:0] text_byte          | -           | end_of_content
//  m_*      | out       | [31:0] float_word        | [0] bad_escape | -
//
// One character is taken per cycle. The character that completes a word is
// written into the byte queue at its accept edge; m_tvalid rises when the
// back end pops it into the output register, which waits while an earlier word is not taken.
// The front end stalls only when the byte queue is full; the queue drains one
// item per cycle whenever the output register is empty or being taken.
// Synchronous reset clears escape state, queue pointers and the partial word.
module escaped_text_to_float_words #(
  parameter int QueueDepth = eswf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_content
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] float_word
  output logic        m_tuser    // [0] bad_escape
);
  import eswf_pkg::*;

  logic       push, pop, q_full, q_valid;
  byte_item_t push_item, head_item;

  eswf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_char   (s_tdata),
    .in_last   (s_tlast),
    .q_full    (q_full),
    .in_ready  (s_tready),
    .push      (push),
    .push_item (push_item)
  );

  eswf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  eswf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata),
    .out_err   (m_tuser)
  );

  // no word can appear right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // back end drains the queue whenever the output side has room
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && (!m_tvalid || m_tready)) |-> pop)
    else $error("queue stalled with room at output");

  // never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");

  // a stalled queue entry must not be overwritten: a full queue blocks input
  assert property (@(posedge clk) disable iff (rst) q_full |-> !push)
    else $error("push into full queue");

endmodule
